// ===== hw/rtl/cmre_pkg.sv =====
// ----------------------------------------------------------------------------
// cmre_pkg
// Types, widths and fixed constants shared by the column envelope blocks.
// ----------------------------------------------------------------------------
package cmre_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int LEVEL_BITS  = 16;
    localparam int COUNT_BITS  = 16;
    localparam int INDEX_BITS  = 16;

    localparam int ABS_W      = SAMPLE_BITS + COUNT_BITS;
    localparam int SQ_W       = 2 * SAMPLE_BITS + COUNT_BITS - 1;
    localparam int MEAN_SHIFT = 33 - SAMPLE_BITS;
    localparam int MS_SHIFT   = 50 - 2 * SAMPLE_BITS;
    localparam int DIV_W      = SQ_W + MS_SHIFT;
    localparam int REM_W      = COUNT_BITS + 1;
    localparam int STEP_W     = $clog2(DIV_W + 1);

    localparam int Q32_W   = 33;
    localparam int ROOT_W  = 25;
    localparam int MSQ_W   = 2 * ROOT_W - 1;
    localparam int LOG_Y_W = 31;
    localparam int L_FRAC  = 24;
    localparam int L_W     = L_FRAC + 1;
    localparam int GAIN_W  = 24;
    localparam int GPROD_W = L_W + GAIN_W;
    localparam int LVL_SHIFT = 48 - LEVEL_BITS;

    localparam logic [Q32_W-1:0]  OFFSET_Q32 = Q32_W'(4294967);
    localparam logic [GAIN_W-1:0] GAIN_Q24   = GAIN_W'(16767478);
    localparam logic [GPROD_W-1:0] LVL_ROUND = GPROD_W'(1) << (LVL_SHIFT - 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_sample;
    } item_t;

    typedef struct packed {
        logic [INDEX_BITS-1:0] column_index;
        logic [LEVEL_BITS-1:0] mean_level;
        logic [LEVEL_BITS-1:0] rms_level;
        logic                  last_column;
    } result_t;

    typedef struct packed {
        logic                  zero_only;
        logic                  then_zero;
        logic [ABS_W-1:0]      abs_sum;
        logic [SQ_W-1:0]       square_sum;
        logic [COUNT_BITS-1:0] count;
        logic [INDEX_BITS-1:0] index;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_DIV,
        B_SQRT,
        B_LOGSEL,
        B_LOGMUL,
        B_LOGADJ,
        B_GAINMUL,
        B_GAINOUT,
        B_EMIT,
        B_EMIT_ZERO
    } back_state_t;

endpackage

// ===== hw/rtl/column_mean_rms_envelope_top.sv =====
// ----------------------------------------------------------------------------
// column_mean_rms_envelope_top
// Groups audio samples into display columns and gives log-scaled mean
// absolute and RMS levels per column.
//
// Input channel: push / full with item (sample, last_sample); a transfer
// happens when push is high and full is low. A sample that does not close
// a column is taken every cycle while full is low.
// Result channel: empty / pop with result; the oldest result is shown while
// empty is low and is transferred when pop is high.
// Config: cfg_wr_en / cfg_wr_data set samples_per_column (reset 40).
// A closing sample hands its sums to a two-entry job queue; the finisher
// then works through each column (two serial divides, a 25-step square
// root, two 24-step squaring log loops), so the job queue fills if columns
// close faster than the finisher completes them. A last sample that
// exactly fills a column yields two results.
// Reset clears sums, column index and both queues. While the result queue
// is full the finisher holds, then the job queue fills and full is raised.
// ----------------------------------------------------------------------------
module column_mean_rms_envelope_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [cmre_pkg::COUNT_BITS-1:0]  cfg_wr_data,
    input  logic                             push,
    input  cmre_pkg::item_t                  item,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output cmre_pkg::result_t                result
);
    import cmre_pkg::*;

    job_t                    job_in, job_out;
    logic                    job_push, job_full, job_pop, job_empty;
    logic [$bits(job_t)-1:0] job_rdata;
    result_t                 res_in;
    logic                    out_push, out_full;
    logic [$bits(result_t)-1:0] out_rdata;

    assign job_out = job_t'(job_rdata);
    assign result  = result_t'(out_rdata);

    cmre_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .push        (push),
        .item        (item),
        .full        (full),
        .job_push    (job_push),
        .job         (job_in),
        .job_full    (job_full)
    );

    cmre_queue #(.WIDTH($bits(job_t))) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_pop),
        .rdata (job_rdata),
        .empty (job_empty)
    );

    cmre_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .result    (res_in)
    );

    cmre_queue #(.WIDTH($bits(result_t))) u_out_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (res_in),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_rdata),
        .empty (empty)
    );

endmodule

// ===== hw/rtl/cmre_queue.sv =====
// ----------------------------------------------------------------------------
// cmre_queue
// Two-entry first-in first-out queue.
// ----------------------------------------------------------------------------
module cmre_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wptr_reg, wptr_next;
    logic             rptr_reg, rptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = mem_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = do_push ? ~wptr_reg : wptr_reg;
        rptr_next  = do_pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= wdata;
        end
    end

endmodule

// ===== hw/rtl/cmre_front.sv =====
// ----------------------------------------------------------------------------
// cmre_front
// Sample accumulator: sums magnitudes and squares and closes columns.
// ----------------------------------------------------------------------------
module cmre_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cmre_pkg::COUNT_BITS-1:0]   cfg_wr_data,
    input  logic                              push,
    input  cmre_pkg::item_t                   item,
    output logic                              full,
    output logic                              job_push,
    output cmre_pkg::job_t                    job,
    input  logic                              job_full
);
    import cmre_pkg::*;

    logic [COUNT_BITS-1:0]  len_reg, len_next;
    logic [ABS_W-1:0]       abs_reg, abs_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [COUNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [INDEX_BITS-1:0]  col_reg, col_next;

    logic [SAMPLE_BITS-1:0]   raw, mag;
    logic [2*SAMPLE_BITS-1:0] sq_term;
    logic [ABS_W-1:0]         abs_new;
    logic [SQ_W-1:0]          sq_new;
    logic [COUNT_BITS-1:0]    cnt_new, len_eff;
    logic                     accept, close;

    assign full = job_full;

    always_comb
    begin
        raw     = item.sample;
        mag     = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;
        sq_term = mag * mag;
        abs_new = abs_reg + ABS_W'(mag);
        sq_new  = sq_reg + SQ_W'(sq_term);
        cnt_new = cnt_reg + 1'b1;
        len_eff = (len_reg == '0) ? COUNT_BITS'(1) : len_reg;
        close   = (cnt_new >= len_eff);
        accept  = push & ~job_full;

        job.zero_only  = ~close;
        job.then_zero  = item.last_sample;
        job.abs_sum    = abs_new;
        job.square_sum = sq_new;
        job.count      = cnt_new;
        job.index      = col_reg;
        job_push       = accept & (close | item.last_sample);

        len_next = cfg_wr_en ? cfg_wr_data : len_reg;
        abs_next = abs_reg;
        sq_next  = sq_reg;
        cnt_next = cnt_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (close || item.last_sample)
            begin
                abs_next = '0;
                sq_next  = '0;
                cnt_next = '0;
                col_next = (item.last_sample) ? '0 : col_reg + 1'b1;
            end
            else
            begin
                abs_next = abs_new;
                sq_next  = sq_new;
                cnt_next = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= COUNT_BITS'(40);
            abs_reg <= '0;
            sq_reg  <= '0;
            cnt_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
            abs_reg <= abs_next;
            sq_reg  <= sq_next;
            cnt_reg <= cnt_next;
            col_reg <= col_next;
        end
    end

endmodule

// ===== hw/rtl/cmre_back.sv =====
// ----------------------------------------------------------------------------
// cmre_back
// Column finisher: serial divide, serial square root, log2 by squaring,
// gain scaling and result emission.
// ----------------------------------------------------------------------------
module cmre_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_empty,
    input  cmre_pkg::job_t       job,
    output logic                 job_pop,
    input  logic                 out_full,
    output logic                 out_push,
    output cmre_pkg::result_t    result
);
    import cmre_pkg::*;

    back_state_t            state_reg, state_next;
    logic                   pass_reg, pass_next;
    logic                   then_zero_reg, then_zero_next;
    logic [INDEX_BITS-1:0]  index_reg, index_next;
    logic [COUNT_BITS-1:0]  n_reg, n_next;
    logic [SQ_W-1:0]        sq_hold_reg, sq_hold_next;
    logic [DIV_W-1:0]       num_reg, num_next;
    logic [REM_W-1:0]       rem_reg, rem_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [2*ROOT_W-1:0]    x_reg, x_next;
    logic [ROOT_W-1:0]      root_reg, root_next;
    logic [ROOT_W:0]        srem_reg, srem_next;
    logic [Q32_W-1:0]       mean32_reg, mean32_next;
    logic [LOG_Y_W-1:0]     y_reg, y_next;
    logic [2*LOG_Y_W-1:0]   ysq_reg, ysq_next;
    logic [L_W-1:0]         l_reg, l_next;
    logic [GPROD_W-1:0]     gprod_reg, gprod_next;
    logic [LEVEL_BITS-1:0]  mean_lvl_reg, mean_lvl_next;
    logic [LEVEL_BITS-1:0]  rms_lvl_reg, rms_lvl_next;

    logic [REM_W-1:0]       rem_sh;
    logic                   div_ge;
    logic [DIV_W-1:0]       num_sh;
    logic [ROOT_W+2:0]      srem_sh, trial, srem_dif;
    logic [Q32_W-1:0]       level, v;
    logic [LOG_Y_W:0]       t;
    logic [GPROD_W-1:0]     rounded;
    logic [LEVEL_BITS:0]    lvl_wide;
    logic [LEVEL_BITS-1:0]  lvl;

    always_comb
    begin
        rem_sh  = {rem_reg[REM_W-2:0], num_reg[DIV_W-1]};
        div_ge  = (rem_sh >= {1'b0, n_reg});
        num_sh  = {num_reg[DIV_W-2:0], div_ge};
        srem_sh = {srem_reg, x_reg[2*ROOT_W-1 -: 2]};
        trial   = {1'b0, root_reg, 2'b01};
        srem_dif = srem_sh - trial;
        level   = pass_reg ? {root_reg, 8'b0} : mean32_reg;
        v       = (level > OFFSET_Q32) ? level - OFFSET_Q32 : '0;
        t       = ysq_reg[2*LOG_Y_W-1 -: LOG_Y_W+1];
        rounded = gprod_reg + LVL_ROUND;
        lvl_wide = rounded[GPROD_W-1 -: LEVEL_BITS+1];
        lvl     = lvl_wide[LEVEL_BITS] ? '1 : lvl_wide[LEVEL_BITS-1:0];

        state_next     = state_reg;
        pass_next      = pass_reg;
        then_zero_next = then_zero_reg;
        index_next     = index_reg;
        n_next         = n_reg;
        sq_hold_next   = sq_hold_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        x_next         = x_reg;
        root_next      = root_reg;
        srem_next      = srem_reg;
        mean32_next    = mean32_reg;
        y_next         = y_reg;
        ysq_next       = ysq_reg;
        l_next         = l_reg;
        gprod_next     = gprod_reg;
        mean_lvl_next  = mean_lvl_reg;
        rms_lvl_next   = rms_lvl_reg;

        job_pop             = 1'b0;
        out_push            = 1'b0;
        result.column_index = index_reg;
        result.mean_level   = mean_lvl_reg;
        result.rms_level    = rms_lvl_reg;
        result.last_column  = 1'b0;

        unique case (state_reg)
            B_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop        = 1'b1;
                    index_next     = job.index;
                    then_zero_next = job.then_zero;
                    n_next         = job.count;
                    sq_hold_next   = job.square_sum;
                    num_next       = DIV_W'(job.abs_sum) << MEAN_SHIFT;
                    rem_next       = '0;
                    step_next      = '0;
                    pass_next      = 1'b0;
                    state_next     = job.zero_only ? B_EMIT_ZERO : B_DIV;
                end
            end
            B_DIV:
            begin
                rem_next  = div_ge ? rem_sh - {1'b0, n_reg} : rem_sh;
                num_next  = num_sh;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    step_next = '0;
                    rem_next  = '0;
                    if (!pass_reg)
                    begin
                        mean32_next = num_sh[Q32_W-1:0];
                        num_next    = DIV_W'(sq_hold_reg) << MS_SHIFT;
                        pass_next   = 1'b1;
                    end
                    else
                    begin
                        x_next     = {1'b0, num_sh[MSQ_W-1:0]};
                        root_next  = '0;
                        srem_next  = '0;
                        state_next = B_SQRT;
                    end
                end
            end
            B_SQRT:
            begin
                x_next    = x_reg << 2;
                step_next = step_reg + 1'b1;
                if (srem_sh >= trial)
                begin
                    srem_next = srem_dif[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    srem_next = srem_sh[ROOT_W:0];
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                if (step_reg == STEP_W'(ROOT_W - 1))
                begin
                    pass_next  = 1'b0;
                    state_next = B_LOGSEL;
                end
            end
            B_LOGSEL:
            begin
                step_next = '0;
                if (v[Q32_W-1])
                begin
                    l_next     = L_W'(1) << L_FRAC;
                    state_next = B_GAINMUL;
                end
                else
                begin
                    y_next     = LOG_Y_W'(1) << 30;
                    y_next     = y_next + LOG_Y_W'(v[Q32_W-2:2]);
                    l_next     = '0;
                    state_next = B_LOGMUL;
                end
            end
            B_LOGMUL:
            begin
                ysq_next   = y_reg * y_reg;
                state_next = B_LOGADJ;
            end
            B_LOGADJ:
            begin
                step_next = step_reg + 1'b1;
                if (t[LOG_Y_W])
                begin
                    y_next = t[LOG_Y_W:1];
                    l_next = l_reg | (L_W'(1) << (5'(L_FRAC - 1) - step_reg[4:0]));
                end
                else
                begin
                    y_next = t[LOG_Y_W-1:0];
                end
                state_next = (step_reg == STEP_W'(L_FRAC - 1)) ? B_GAINMUL : B_LOGMUL;
            end
            B_GAINMUL:
            begin
                gprod_next = l_reg * GAIN_Q24;
                state_next = B_GAINOUT;
            end
            B_GAINOUT:
            begin
                if (!pass_reg)
                begin
                    mean_lvl_next = lvl;
                    pass_next     = 1'b1;
                    state_next    = B_LOGSEL;
                end
                else
                begin
                    rms_lvl_next = lvl;
                    state_next   = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (!out_full)
                begin
                    out_push = 1'b1;
                    if (then_zero_reg)
                    begin
                        index_next = index_reg + 1'b1;
                        state_next = B_EMIT_ZERO;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_EMIT_ZERO:
            begin
                result.mean_level  = '0;
                result.rms_level   = '0;
                result.last_column = 1'b1;
                if (!out_full)
                begin
                    out_push   = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            pass_reg  <= 1'b0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pass_reg  <= pass_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        then_zero_reg <= then_zero_next;
        index_reg     <= index_next;
        n_reg         <= n_next;
        sq_hold_reg   <= sq_hold_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        x_reg         <= x_next;
        root_reg      <= root_next;
        srem_reg      <= srem_next;
        mean32_reg    <= mean32_next;
        y_reg         <= y_next;
        ysq_reg       <= ysq_next;
        l_reg         <= l_next;
        gprod_reg     <= gprod_next;
        mean_lvl_reg  <= mean_lvl_next;
        rms_lvl_reg   <= rms_lvl_next;
    end

endmodule
